// File: rtl/battery_gauge_monitor_assert.svh
// Assertion macros used by the checker file of the battery gauge.
`ifndef BATTERY_GAUGE_MONITOR_ASSERT_SVH
`define BATTERY_GAUGE_MONITOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BGM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BGM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bgm_pkg.sv
// Shared constants, table functions and types of the battery gauge.
package bgm_pkg;

  localparam int HISTORY_DEPTH = 60;
  localparam int MV_BITS       = 14;

  localparam int IDX_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
  localparam int SUM_W  = MV_BITS + CNT_W;
  localparam int VOLT_W = 13;
  localparam int PCT_W  = 7;
  localparam int DP_W   = 4;
  localparam int SEG_W  = 4;
  localparam int TABLE_LAST = 10;
  localparam int MULA_W = (MV_BITS > VOLT_W) ? MV_BITS : VOLT_W;
  localparam int MUL_W  = MULA_W + CNT_W;
  // widest table step is 250 mV, times the count
  localparam int SPAN_W = 10 + CNT_W;
  localparam int DIV_W  = (SUM_W > SPAN_W + DP_W) ? SUM_W : SPAN_W + DP_W;
  localparam int STEP_W = $clog2(DIV_W);
  localparam int TIME_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_HIGH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHARGE_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF     = 3'd4;

  localparam logic [MV_BITS-1:0] RST_CHARGE_HIGH = MV_BITS'(4180);
  localparam logic [MV_BITS-1:0] RST_CHARGE_LOW  = MV_BITS'(4120);
  localparam logic [MV_BITS-1:0] RST_CUTOFF      = MV_BITS'(3000);
  localparam logic [MV_BITS-1:0] RST_FLOOR       = MV_BITS'(2000);
  localparam logic [TIME_W-1:0]  RST_HOLDOFF     = TIME_W'(15000);

  localparam logic OP_SAMPLE  = 1'b0;
  localparam logic OP_PREFILL = 1'b1;

  // Voltage breakpoints of the discharge curve, mV.
  function automatic logic [VOLT_W-1:0] volt_pt(input logic [SEG_W-1:0] k);
    logic [VOLT_W-1:0] v;
    unique case (k)
      4'd0:    v = 13'd3100;
      4'd1:    v = 13'd3350;
      4'd2:    v = 13'd3450;
      4'd3:    v = 13'd3550;
      4'd4:    v = 13'd3620;
      4'd5:    v = 13'd3680;
      4'd6:    v = 13'd3740;
      4'd7:    v = 13'd3800;
      4'd8:    v = 13'd3880;
      4'd9:    v = 13'd3980;
      default: v = 13'd4120;
    endcase
    return v;
  endfunction

  // Percentages at the breakpoints.
  function automatic logic [PCT_W-1:0] pct_pt(input logic [SEG_W-1:0] k);
    logic [PCT_W-1:0] p;
    unique case (k)
      4'd0:    p = 7'd1;
      4'd1:    p = 7'd5;
      4'd2:    p = 7'd10;
      4'd3:    p = 7'd20;
      4'd4:    p = 7'd30;
      4'd5:    p = 7'd40;
      4'd6:    p = 7'd50;
      4'd7:    p = 7'd60;
      4'd8:    p = 7'd70;
      4'd9:    p = 7'd85;
      default: p = 7'd100;
    endcase
    return p;
  endfunction

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   addr;
    logic [MV_BITS-1:0] data;
  } hist_wr_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  num;
    logic [SPAN_W-1:0] den;
  } div_req_t;

endpackage

// File: rtl/bgm_hist_mem.sv
// Sample history RAM: one write port, one registered read port, per-entry valid bits.
module bgm_hist_mem
  import bgm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  hist_wr_t           wr,
  input  logic               rd_en,
  input  logic [IDX_W-1:0]   rd_addr,
  output logic [MV_BITS-1:0] rd_data
);

  logic [MV_BITS-1:0]       mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] valid;
  logic [MV_BITS-1:0]       mem_q;
  logic                     vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // never-written entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_q <= valid[rd_addr];
      end
    end
  end

  assign rd_data = vld_q ? mem_q : '0;

endmodule

// File: rtl/bgm_div.sv
// Restoring divider, one quotient bit per cycle, shared by average and interpolation.
module bgm_div
  import bgm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DIV_W-1:0]  acc;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] den;
  logic [SPAN_W:0]   trial;
  logic [SPAN_W:0]   diff;
  logic              ge;

  assign trial = {rem, acc[DIV_W-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= busy && !req.start && (step == STEP_W'(DIV_W - 1));
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DIV_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // dividend shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= req.num;
      rem <= '0;
      den <= req.den;
    end else if (busy) begin
      acc <= {acc[DIV_W-2:0], ge};
      rem <= ge ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];
    end
  end

  assign quo = acc;

endmodule

// File: rtl/battery_gauge_monitor.sv
// Top level of the moving-average battery fuel gauge.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  in      | sink      | in_valid / in_ready   | op, sample_mv, usb_host_present, time_ms
//  out     | source    | out_valid / out_ready | avg_mv, percent, charging,
//          |           |                       | charging_changed, percent_changed, power_off
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item at a time. A sample walks the table points in order (1 to 11 of them) and
// needs a second divide when the average falls between two points; both divides are
// 20-bit passes of the shared radix-2 divider. A prefill writes all 60 entries,
// one history RAM write per cycle. A zero sample is taken and dropped with no result.
// Reset is synchronous; the RAM needs no clearing pass (valid bits reset at once).
// The result register lets the next item in while a result waits for out_ready;
// a new result waits in the final state only while the previous one is still held.
module battery_gauge_monitor
  import bgm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // input samples
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [MV_BITS-1:0]    sample_mv,
  input  logic                  usb_host_present,
  input  logic [TIME_W-1:0]     time_ms,
  // results
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MV_BITS-1:0]    avg_mv,
  output logic [PCT_W-1:0]      percent,
  output logic                  charging,
  output logic                  charging_changed,
  output logic                  percent_changed,
  output logic                  power_off,
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,    // ready for a transfer
    S_FILL,    // prefill sweep over the RAM
    S_UPD,     // old entry back from RAM: update sum, write new sample
    S_DIVA,    // launch sum / count
    S_WAITA,
    S_FLOOR,   // sum >= floor * count
    S_CUT,     // sum <  cutoff * count
    S_SEARCH,  // walk table points until sum <= point * count
    S_DPMUL,   // offset times percent step
    S_DIVP,    // launch interpolation divide
    S_WAITP,
    S_FIN      // load result register
  } state_t;

  state_t state;

  // configuration
  logic [MV_BITS-1:0] chg_high;
  logic [MV_BITS-1:0] chg_low;
  logic [MV_BITS-1:0] cutoff;
  logic [MV_BITS-1:0] floor_lvl;
  logic [TIME_W-1:0]  holdoff;

  // gauge state
  logic [IDX_W-1:0]   widx;
  logic               full;
  logic [SUM_W-1:0]   sum_r;
  logic               chg;
  logic [PCT_W-1:0]   shown;

  // per-item working registers
  logic [MV_BITS-1:0] s_r;
  logic               host_r;
  logic [TIME_W-1:0]  time_r;
  logic               chg_flip;
  logic [CNT_W-1:0]   cnt_r;
  logic [IDX_W-1:0]   fill_idx;
  logic [MV_BITS-1:0] avg_r;
  logic               ge_floor_r;
  logic               lt_cut_r;
  logic [SEG_W-1:0]   seg;
  logic [MUL_W-1:0]   prod_prev;
  logic [SPAN_W-1:0]  off_r;
  logic [SPAN_W-1:0]  span_r;
  logic [DIV_W-1:0]   numer_r;
  logic [PCT_W-1:0]   pct_r;

  logic               accept;
  logic               chg_next;
  logic [MV_BITS-1:0] old_mv;
  logic [CNT_W-1:0]   widx_inc;
  logic               wrap;
  logic [MULA_W-1:0]  mul_a;
  logic [MUL_W-1:0]   prod;
  logic [MUL_W-1:0]   sum_x;
  logic               hit;
  logic [SEG_W-1:0]   seg_lo;
  logic [PCT_W-1:0]   dp_full;
  logic [MUL_W-1:0]   off_full;
  logic [MUL_W-1:0]   span_full;
  logic               out_free;
  hist_wr_t           hist_wr;
  div_req_t           div_req;
  logic               div_done;
  logic [DIV_W-1:0]   div_quo;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // hysteresis on the raw sample
  always_comb begin
    chg_next = chg;
    if (sample_mv >= chg_high) begin
      chg_next = 1'b1;
    end else if (chg && (sample_mv < chg_low)) begin
      chg_next = 1'b0;
    end
  end

  bgm_hist_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr      (hist_wr),
    .rd_en   (accept),
    .rd_addr (widx),
    .rd_data (old_mv)
  );

  always_comb begin
    hist_wr.en   = (state == S_FILL) || (state == S_UPD);
    hist_wr.addr = (state == S_FILL) ? fill_idx : widx;
    hist_wr.data = s_r;
  end

  assign widx_inc = CNT_W'(widx) + 1'b1;
  assign wrap     = (widx_inc == CNT_W'(HISTORY_DEPTH));

  // one shared multiplier against the filled count
  always_comb begin
    unique case (state)
      S_FLOOR: mul_a = MULA_W'(floor_lvl);
      S_CUT:   mul_a = MULA_W'(cutoff);
      default: mul_a = MULA_W'(volt_pt(seg));
    endcase
  end

  assign prod      = MUL_W'(mul_a) * MUL_W'(cnt_r);
  assign sum_x     = MUL_W'(sum_r);
  assign hit       = sum_x <= prod;
  assign off_full  = sum_x - prod_prev;
  assign span_full = prod - prod_prev;
  assign seg_lo    = seg - 1'b1;
  assign dp_full   = pct_pt(seg) - pct_pt(seg_lo);

  always_comb begin
    div_req.start = (state == S_DIVA) || (state == S_DIVP);
    div_req.num   = (state == S_DIVP) ? numer_r : DIV_W'(sum_r);
    div_req.den   = (state == S_DIVP) ? span_r  : SPAN_W'(cnt_r);
  end

  bgm_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .done (div_done),
    .quo  (div_quo)
  );

  // register writes; out-of-range indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      chg_high  <= RST_CHARGE_HIGH;
      chg_low   <= RST_CHARGE_LOW;
      cutoff    <= RST_CUTOFF;
      floor_lvl <= RST_FLOOR;
      holdoff   <= RST_HOLDOFF;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CHARGE_HIGH: chg_high  <= cfg_data[MV_BITS-1:0];
        REG_CHARGE_LOW:  chg_low   <= cfg_data[MV_BITS-1:0];
        REG_CUTOFF:      cutoff    <= cfg_data[MV_BITS-1:0];
        REG_FLOOR:       floor_lvl <= cfg_data[MV_BITS-1:0];
        REG_HOLDOFF:     holdoff   <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      widx      <= '0;
      full      <= 1'b0;
      sum_r     <= '0;
      chg       <= 1'b0;
      shown     <= '0;
      out_valid <= 1'b0;
    end else begin
      // the final state reloads the result register itself
      if (out_valid && out_ready && (state != S_FIN)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            s_r    <= sample_mv;
            host_r <= usb_host_present;
            time_r <= time_ms;
            if (op == OP_PREFILL) begin
              fill_idx <= '0;
              widx     <= '0;
              full     <= 1'b1;
              sum_r    <= SUM_W'(sample_mv) * SUM_W'(HISTORY_DEPTH);
              state    <= S_FILL;
            end else if (sample_mv != '0) begin
              chg      <= chg_next;
              chg_flip <= chg_next != chg;
              state    <= S_UPD;
            end
          end
        end
        S_FILL: begin
          fill_idx <= fill_idx + 1'b1;
          if (fill_idx == IDX_W'(HISTORY_DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_UPD: begin
          sum_r <= sum_r - SUM_W'(old_mv) + SUM_W'(s_r);
          cnt_r <= (full || wrap) ? CNT_W'(HISTORY_DEPTH) : widx_inc;
          if (wrap) begin
            widx <= '0;
            full <= 1'b1;
          end else begin
            widx <= IDX_W'(widx_inc);
          end
          state <= S_DIVA;
        end
        S_DIVA: begin
          state <= S_WAITA;
        end
        S_WAITA: begin
          if (div_done) begin
            avg_r <= div_quo[MV_BITS-1:0];
            state <= S_FLOOR;
          end
        end
        S_FLOOR: begin
          ge_floor_r <= sum_x >= prod;
          state      <= S_CUT;
        end
        S_CUT: begin
          lt_cut_r <= sum_x < prod;
          seg      <= '0;
          state    <= S_SEARCH;
        end
        S_SEARCH: begin
          prod_prev <= prod;
          if (hit) begin
            if (seg == '0) begin
              // at or below the lowest point
              pct_r <= pct_pt(seg);
              state <= S_FIN;
            end else begin
              off_r  <= off_full[SPAN_W-1:0];
              span_r <= span_full[SPAN_W-1:0];
              state  <= S_DPMUL;
            end
          end else if (seg == SEG_W'(TABLE_LAST)) begin
            // above the top point
            pct_r <= pct_pt(seg);
            state <= S_FIN;
          end else begin
            seg <= seg + 1'b1;
          end
        end
        S_DPMUL: begin
          numer_r <= DIV_W'(off_r) * DIV_W'(dp_full[DP_W-1:0]);
          state   <= S_DIVP;
        end
        S_DIVP: begin
          state <= S_WAITP;
        end
        S_WAITP: begin
          if (div_done) begin
            pct_r <= pct_pt(seg_lo) + div_quo[PCT_W-1:0];
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid        <= 1'b1;
            avg_mv           <= avg_r;
            percent          <= pct_r;
            charging         <= chg;
            charging_changed <= chg_flip;
            percent_changed  <= (shown == '0) || (shown != pct_r);
            power_off        <= !chg && !host_r && ge_floor_r && lt_cut_r &&
                                (time_r >= holdoff);
            shown            <= pct_r;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/bgm_checker.sv
// Port-level checker for the battery gauge, bound to the top level.
`include "battery_gauge_monitor_assert.svh"

module bgm_checker
  import bgm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               op,
  input logic [MV_BITS-1:0] sample_mv,
  input logic               out_valid,
  input logic               out_ready,
  input logic [MV_BITS-1:0] avg_mv,
  input logic [PCT_W-1:0]   percent,
  input logic               charging,
  input logic               power_off
);

  // a held result keeps its payload
  `BGM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(avg_mv) && $stable(percent), "result changed while stalled")

  `BGM_ASSERT_NOW(a_pct_range, out_valid, (percent >= 7'd1) && (percent <= 7'd100), "percent out of range")

  `BGM_ASSERT_NOW(a_poff_chg, out_valid && power_off, !charging, "power-off while charging")

  // a sample or prefill occupies the block for at least the next cycle
  `BGM_ASSERT_NEXT(a_busy_after, in_valid && in_ready && (op || (sample_mv != '0)), !in_ready, "input taken while busy")

endmodule

bind battery_gauge_monitor bgm_checker u_bgm_checker (.*);
